FILE: rtl/color_scharr_gradient_defines.svh
// Assertion macros used by the block's top-level module.
`ifndef COLOR_SCHARR_GRADIENT_DEFINES_SVH
`define COLOR_SCHARR_GRADIENT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CSG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csg: implication check failed");
// next-cycle implication
`define CSG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csg: next-cycle check failed");
`else
`define CSG_ASSERT_IMP(lbl, ante, cons)
`define CSG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/csg_pkg.sv
package csg_pkg;

  localparam int CHANNELS     = 3;
  localparam int MAX_WIDTH    = 4096;
  localparam int CH_W         = 16;
  localparam int PIX_W        = CHANNELS * CH_W + 1;
  localparam int COL_W        = 12;
  localparam int DIM_W        = 13;
  localparam int G_W          = 21;
  localparam int SQH_W        = 41;
  localparam int NC_W         = 42;
  localparam int SQ_IN_W      = 44;
  localparam int SQ_STEPS     = SQ_IN_W / 2;
  localparam int ROOT_W       = 22;
  localparam int REM_W        = 24;
  localparam int S_W          = 21;
  localparam int P_W          = 43;
  localparam int CS_W         = 45;
  localparam int CX_W         = 47;
  localparam int Z_W          = 34;
  localparam int CORDIC_STEPS = 20;
  localparam int MAG_W        = 22;
  localparam int DIR_W        = 16;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_AXIAL  = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [DIM_W-1:0] DIM_MIN    = 13'd3;
  localparam logic [DIM_W-1:0] DIM_MAX    = 13'd4096;

  localparam logic signed [Z_W-1:0] PI_UNITS = 34'sh080000000;
  localparam logic signed [Z_W-1:0] Z_ROUND  = 34'sd32768;

  typedef logic signed [CH_W-1:0] chan_t;

  typedef struct packed {
    logic                           valid;
    logic [CHANNELS-1:0][CH_W-1:0]  ch;
  } pixel_t;

  typedef struct packed {
    chan_t l0, l1, l2, m0, m2, r0, r1, r2;
  } lane_win_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LANE,
    ST_MERGE,
    ST_EMIT
  } state_t;

  function automatic logic [30:0] atan_entry(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:    v = 31'd536870912;
      5'd1:    v = 31'd316933406;
      5'd2:    v = 31'd167458907;
      5'd3:    v = 31'd85004756;
      5'd4:    v = 31'd42667331;
      5'd5:    v = 31'd21354465;
      5'd6:    v = 31'd10679838;
      5'd7:    v = 31'd5340245;
      5'd8:    v = 31'd2670163;
      5'd9:    v = 31'd1335087;
      5'd10:   v = 31'd667544;
      5'd11:   v = 31'd333772;
      5'd12:   v = 31'd166886;
      5'd13:   v = 31'd83443;
      5'd14:   v = 31'd41722;
      5'd15:   v = 31'd20861;
      5'd16:   v = 31'd10430;
      5'd17:   v = 31'd5215;
      5'd18:   v = 31'd2608;
      5'd19:   v = 31'd1304;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/csg_ram.sv
module csg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/csg_isqrt.sv
module csg_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [csg_pkg::SQ_IN_W-1:0]   value_i,
  output logic                          done_o,
  output logic [csg_pkg::ROOT_W-1:0]    root_o
);
  import csg_pkg::*;

  logic [SQ_IN_W-1:0] val_r, val_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [REM_W+1:0]   cand, trial;

  // one root bit per cycle, two radicand bits shifted in
  always_comb begin
    cand     = {rem_r, val_r[SQ_IN_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start_i) begin
      val_nxt  = value_i;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      val_nxt = {val_r[SQ_IN_W-3:0], 2'b00};
      if (cand >= trial) begin
        rem_nxt  = REM_W'(cand - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(cand);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(SQ_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done_o = done_r;
  assign root_o = root_r;

endmodule

FILE: rtl/csg_lane.sv
module csg_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  csg_pkg::lane_win_t                win_i,
  input  logic                              axial_i,
  output logic                              done_o,
  output logic [csg_pkg::NC_W-1:0]          nc_o,
  output logic signed [csg_pkg::P_W-1:0]    px_o,
  output logic signed [csg_pkg::P_W-1:0]    py_o
);
  import csg_pkg::*;

  function automatic logic signed [G_W-1:0] ext(input chan_t v);
    return {{(G_W-CH_W){v[CH_W-1]}}, v};
  endfunction

  function automatic logic signed [G_W-1:0] x3(input chan_t v);
    return (ext(v) <<< 1) + ext(v);
  endfunction

  function automatic logic signed [G_W-1:0] x10(input chan_t v);
    return (ext(v) <<< 3) + (ext(v) <<< 1);
  endfunction

  logic signed [G_W-1:0]  gx_c, gy_c, gx_r, gy_r;
  logic signed [NC_W-1:0] sqx_c, sqy_c;
  logic [SQH_W-1:0]       sqx_r, sqy_r;
  logic [NC_W-1:0]        nc_r;
  logic                   v1_r, v2_r, done_r;
  logic                   sq_done;
  logic [ROOT_W-1:0]      root;
  logic signed [P_W-1:0]  px_r, py_r;

  always_comb begin
    gx_c = x3(win_i.r0) + x10(win_i.r1) + x3(win_i.r2)
         - x3(win_i.l0) - x10(win_i.l1) - x3(win_i.l2);
    gy_c = x3(win_i.l2) + x10(win_i.m2) + x3(win_i.r2)
         - x3(win_i.l0) - x10(win_i.m0) - x3(win_i.r0);
    // fold to nonnegative x in axial mode
    if (axial_i && gx_c[G_W-1]) begin
      gx_c = -gx_c;
      gy_c = -gy_c;
    end
    sqx_c = gx_r * gx_r;
    sqy_c = gy_r * gy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start_i;
      v2_r   <= v1_r;
      done_r <= sq_done;
    end
    if (start_i) begin
      gx_r <= gx_c;
      gy_r <= gy_c;
    end
    if (v1_r) begin
      sqx_r <= SQH_W'(sqx_c);
      sqy_r <= SQH_W'(sqy_c);
    end
    if (v2_r) begin
      nc_r <= NC_W'({1'b0, sqx_r}) + NC_W'({1'b0, sqy_r});
    end
    if (sq_done) begin
      px_r <= $signed({1'b0, root[S_W-1:0]}) * gx_r;
      py_r <= $signed({1'b0, root[S_W-1:0]}) * gy_r;
    end
  end

  csg_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (v2_r),
    .value_i (SQ_IN_W'({1'b0, sqx_r}) + SQ_IN_W'({1'b0, sqy_r})),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign done_o = done_r;
  assign nc_o   = nc_r;
  assign px_o   = px_r;
  assign py_o   = py_r;

endmodule

FILE: rtl/csg_merge.sv
module csg_merge (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           start_i,
  input  logic [csg_pkg::CHANNELS-1:0][csg_pkg::NC_W-1:0] nc_i,
  input  logic [csg_pkg::CHANNELS-1:0][csg_pkg::P_W-1:0]  px_i,
  input  logic [csg_pkg::CHANNELS-1:0][csg_pkg::P_W-1:0]  py_i,
  output logic                                           done_o,
  output logic [csg_pkg::MAG_W-1:0]                      mag_o,
  output logic [csg_pkg::DIR_W-1:0]                      dir_o
);
  import csg_pkg::*;

  logic [SQ_IN_W-1:0]     sum_c, sum_r;
  logic signed [CS_W-1:0] cs_c, sn_c, cs_r, sn_r;
  logic                   load_r, cd_run_r, zero_r, done_r;
  logic [4:0]             cd_cnt_r;
  logic signed [CX_W-1:0] x_r, y_r, x_nxt, y_nxt, x0, y0, xs, ys;
  logic signed [Z_W-1:0]  z_r, z_nxt, z_rnd, atan_v;
  logic                   sq_done;
  logic [ROOT_W-1:0]      root;
  logic [DIR_W-1:0]       dir_r;

  always_comb begin
    sum_c = '0;
    cs_c  = '0;
    sn_c  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum_c = sum_c + SQ_IN_W'(nc_i[c]);
      cs_c  = cs_c + CS_W'($signed(px_i[c]));
      sn_c  = sn_c + CS_W'($signed(py_i[c]));
    end
  end

  // CORDIC vectoring: drive y to zero, accumulate the angle in z
  always_comb begin
    x0     = CX_W'(cs_r);
    y0     = CX_W'(sn_r);
    xs     = x_r >>> cd_cnt_r;
    ys     = y_r >>> cd_cnt_r;
    atan_v = Z_W'(atan_entry(cd_cnt_r));
    x_nxt  = x_r;
    y_nxt  = y_r;
    z_nxt  = z_r;
    if (load_r) begin
      if (cs_r < 0) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = (sn_r >= 0) ? PI_UNITS : -PI_UNITS;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
    end else if (cd_run_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_v;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_v;
      end
    end
    z_rnd = z_r + Z_ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r   <= 1'b0;
      cd_run_r <= 1'b0;
      cd_cnt_r <= '0;
      done_r   <= 1'b0;
    end else begin
      load_r <= start_i;
      done_r <= sq_done;
      if (load_r) begin
        cd_run_r <= 1'b1;
        cd_cnt_r <= '0;
      end else if (cd_run_r) begin
        cd_cnt_r <= cd_cnt_r + 5'd1;
        if (cd_cnt_r == 5'(CORDIC_STEPS - 1)) begin
          cd_run_r <= 1'b0;
        end
      end
    end
    if (start_i) begin
      sum_r <= sum_c;
      cs_r  <= cs_c;
      sn_r  <= sn_c;
    end
    if (load_r) begin
      zero_r <= (cs_r == '0) && (sn_r == '0);
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    // the root takes longer than the CORDIC, so z is final here
    if (sq_done) begin
      dir_r <= zero_r ? '0 : z_rnd[DIR_W+15:16];
    end
  end

  csg_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (load_r),
    .value_i (sum_r),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign done_o = done_r;
  assign mag_o  = root;
  assign dir_o  = dir_r;

endmodule

FILE: rtl/color_scharr_gradient.sv
// Colour Scharr gradient over a raster pixel stream.
// Input channel: in_valid / in_stall carry one pixel item (three signed Q8.7
// channels and a mask bit) in raster order. Output channel: out_valid /
// out_stall carry one result item (magnitude, direction, frame_last,
// frame_max) for every interior pixel; border pixels give no item.
// Configuration: APB-style port, registers image_width at 0x0,
// image_height at 0x4, axial_mode at 0x8; write only while idle.
// Throughput: one pixel at a time. An unmasked interior pixel passes two
// bit-serial square roots in series (per-channel in the lanes, then the
// sum in the merge stage), the 20-step CORDIC running alongside.
// The result waits in an output register; the next pixel is accepted while
// it stalls, and the block holds only if a second result is ready first.
// Reset (rst_n low, synchronous) restores the default size, clears the
// counters, the window and the frame maximum; line buffers are not cleared.
module color_scharr_gradient (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [15:0]                  in_chan_zero,
  input  logic [15:0]                  in_chan_one,
  input  logic [15:0]                  in_chan_two,
  input  logic                         in_pixel_valid,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [21:0]                  out_magnitude,
  output logic [15:0]                  out_direction,
  output logic                         out_frame_last,
  output logic [21:0]                  out_frame_max,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csg_pkg::ADDR_W-1:0]   paddr,
  input  logic [csg_pkg::DATA_W-1:0]   pwdata,
  output logic [csg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import csg_pkg::*;
  `include "color_scharr_gradient_defines.svh"

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] width_r, height_r, w_eff, h_eff;
  logic             axial_r;
  logic [COL_W-1:0] col_r, row_r;
  logic [MAG_W-1:0] max_r, max_new;
  pixel_t           cur_r, up_rd, mid_rd;
  pixel_t           win_r [6];
  logic [PIX_W-1:0] up_q, mid_q;
  logic             ok_c, ok_r, interior, col_wrap, frame_end;

  logic             in_acc, ram_we, lane_start, merge_start, load_out, advance, out_free;
  logic [CHANNELS-1:0] lane_done;
  lane_win_t        lw [CHANNELS];
  logic [CHANNELS-1:0][NC_W-1:0] nc;
  logic [CHANNELS-1:0][P_W-1:0]  px, py;
  logic             merge_done;
  logic [MAG_W-1:0] m_mag, res_mag;
  logic [DIR_W-1:0] m_dir;

  logic             out_valid_r;
  logic [MAG_W-1:0] out_mag_r, out_max_r;
  logic [DIR_W-1:0] out_dir_r;
  logic             out_last_r;

  // configuration
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_AXIAL:  prdata = DATA_W'(axial_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      axial_r  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_AXIAL:  axial_r  <= pwdata[0];
        default:    ;
      endcase
    end
  end

  assign w_eff = (width_r < DIM_MIN) ? DIM_MIN : ((width_r > DIM_MAX) ? DIM_MAX : width_r);
  assign h_eff = (height_r < DIM_MIN) ? DIM_MIN
               : ((height_r > DIM_MAX) ? DIM_MAX : height_r);

  // line buffers, read at the current column and rewritten in the cycle after the read
  csg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk (clk), .we (ram_we), .addr (col_r), .wdata (mid_q), .rdata (up_q)
  );
  csg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk (clk), .we (ram_we), .addr (col_r), .wdata (PIX_W'(cur_r)), .rdata (mid_q)
  );
  assign up_rd  = pixel_t'(up_q);
  assign mid_rd = pixel_t'(mid_q);

  assign interior  = (col_r >= COL_W'(2)) && (row_r >= COL_W'(2));
  assign col_wrap  = (DIM_W'(col_r) + DIM_W'(1)) >= w_eff;
  assign frame_end = col_wrap && ((DIM_W'(row_r) + DIM_W'(1)) >= h_eff);
  assign ok_c = win_r[0].valid && win_r[1].valid && win_r[2].valid
             && win_r[3].valid && win_r[4].valid && win_r[5].valid
             && up_rd.valid && mid_rd.valid && cur_r.valid;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    always_comb begin
      lw[c].l0 = win_r[0].ch[c];
      lw[c].l1 = win_r[1].ch[c];
      lw[c].l2 = win_r[2].ch[c];
      lw[c].m0 = win_r[3].ch[c];
      lw[c].m2 = win_r[5].ch[c];
      lw[c].r0 = up_rd.ch[c];
      lw[c].r1 = mid_rd.ch[c];
      lw[c].r2 = cur_r.ch[c];
    end
    csg_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start_i (lane_start),
      .win_i   (lw[c]),
      .axial_i (axial_r),
      .done_o  (lane_done[c]),
      .nc_o    (nc[c]),
      .px_o    (px[c]),
      .py_o    (py[c])
    );
  end

  csg_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (merge_start),
    .nc_i    (nc),
    .px_i    (px),
    .py_i    (py),
    .done_o  (merge_done),
    .mag_o   (m_mag),
    .dir_o   (m_dir)
  );

  // sequencer
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  if (!interior) state_nxt = ST_IDLE;
                else if (ok_c) state_nxt = ST_LANE;
                else state_nxt = ST_EMIT;
      ST_LANE:  if (&lane_done) state_nxt = ST_MERGE;
      ST_MERGE: if (merge_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    ram_we      = 1'b0;
    lane_start  = 1'b0;
    merge_start = 1'b0;
    load_out    = 1'b0;
    advance     = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_READ:  begin
        ram_we     = 1'b1;
        lane_start = interior && ok_c;
        advance    = !interior;
      end
      ST_LANE:  merge_start = &lane_done;
      ST_MERGE: ;
      ST_EMIT:  begin
        load_out = out_free;
        advance  = out_free;
      end
      default:  ;
    endcase
  end

  assign in_acc  = in_valid && !in_stall;
  assign res_mag = ok_r ? m_mag : '0;
  assign max_new = (load_out && ok_r && (m_mag > max_r)) ? m_mag : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      max_r   <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        // shift the window one column left
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= up_rd;
        win_r[4] <= mid_rd;
        win_r[5] <= cur_r;
      end
      if (advance) begin
        max_r <= frame_end ? '0 : max_new;
        if (col_wrap) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + COL_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
    if (in_acc) begin
      cur_r <= {in_pixel_valid, in_chan_two, in_chan_one, in_chan_zero};
    end
    if (ram_we) begin
      ok_r <= ok_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_mag_r  <= res_mag;
      out_dir_r  <= ok_r ? m_dir : '0;
      out_last_r <= frame_end;
      out_max_r  <= max_new;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_magnitude  = out_mag_r;
  assign out_direction  = out_dir_r;
  assign out_frame_last = out_last_r;
  assign out_frame_max  = out_max_r;

  `CSG_ASSERT_NXT(a_accept_reads, in_acc, state_r == ST_READ)
  `CSG_ASSERT_IMP(a_lanes_in_step, |lane_done, &lane_done)
  `CSG_ASSERT_IMP(a_merge_only_ok, state_r == ST_MERGE && merge_done, ok_r)
  `CSG_ASSERT_NXT(a_emit_holds, state_r == ST_EMIT && !out_free, state_r == ST_EMIT && out_valid_r)

endmodule

FILE: tb/color_scharr_gradient_tb.sv
`timescale 1ns / 1ps

module color_scharr_gradient_tb;
  import csg_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1550;

  typedef struct packed {
    logic             valid;
    logic [2:0][15:0] ch;
  } pix_s;

  typedef struct packed {
    logic [21:0] mag;
    logic [15:0] dir;
    logic        last;
    logic [21:0] fmax;
  } grad_s;

  typedef struct packed {
    pix_s  pix;
    logic  typed;
    grad_s res;
  } stim_row_s;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_chan_zero, in_chan_one, in_chan_two;
  logic        in_pixel_valid;
  logic        out_valid;
  logic        out_stall;
  logic [21:0] out_magnitude;
  logic [15:0] out_direction;
  logic        out_frame_last;
  logic [21:0] out_frame_max;
  logic        psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  color_scharr_gradient u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_chan_zero(in_chan_zero), .in_chan_one(in_chan_one),
    .in_chan_two(in_chan_two), .in_pixel_valid(in_pixel_valid),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_magnitude(out_magnitude), .out_direction(out_direction),
    .out_frame_last(out_frame_last), .out_frame_max(out_frame_max),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  int unsigned cfg_width, cfg_height, cfg_axial;
  pix_s        upper_row[MAX_WIDTH];
  pix_s        middle_row[MAX_WIDTH];
  pix_s        win[6];
  int unsigned col_pos, row_pos, frame_peak;

  grad_s       pending_grads[$];
  stim_row_s   directed_rows[$];
  int          mismatches, results_seen, items_sent, frames_run;
  longint      cycles;

  localparam longint ATAN_STEP[20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (y <= 0) ? 64'sd2147483648 : -64'sd2147483648;
    end
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end
    end
    return (z + 32768) >>> 16;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v);
    return (v < 3) ? 3 : (v > 4096) ? 4096 : v;
  endfunction

  function automatic longint chv(pix_s p, int c);
    return longint'($signed(p.ch[c]));
  endfunction

  // Advance the stream model by one pixel; returns 1 when a result is due.
  function automatic bit gradient_step(input pix_s cur, output grad_s r);
    int unsigned w, h, x, y;
    pix_s col[3];
    bit ok, due;
    longint gx, gy, nc, s, cs, sn, dir;
    longint unsigned total, mag;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    x = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    y = row_pos;
    r = '0;
    col[0] = upper_row[x];
    col[1] = middle_row[x];
    col[2] = cur;
    upper_row[x] = col[1];
    middle_row[x] = cur;
    due = (x >= 2 && y >= 2);
    if (due) begin
      ok = 1;
      for (int k = 0; k < 3; k++)
        ok = ok && win[k].valid && win[3+k].valid && col[k].valid;
      mag = 0;
      dir = 0;
      if (ok) begin
        total = 0; cs = 0; sn = 0;
        for (int c = 0; c < CHANNELS; c++) begin
          gx = 3*chv(col[0],c) + 10*chv(col[1],c) + 3*chv(col[2],c)
             - 3*chv(win[0],c) - 10*chv(win[1],c) - 3*chv(win[2],c);
          gy = 3*chv(win[2],c) + 10*chv(win[5],c) + 3*chv(col[2],c)
             - 3*chv(win[0],c) - 10*chv(win[3],c) - 3*chv(col[0],c);
          if (cfg_axial != 0 && gx < 0) begin
            gx = -gx;
            gy = -gy;
          end
          nc = gx*gx + gy*gy;
          total += nc;
          s = longint'(floor_sqrt(nc));
          cs += s*gx;
          sn += s*gy;
        end
        mag = floor_sqrt(total);
        if (mag > 4194303) mag = 4194303;
        dir = cordic_angle(cs, sn);
        if (mag > frame_peak) frame_peak = mag;
      end
      r.mag  = mag[21:0];
      r.dir  = dir[15:0];
      r.last = (x + 1 >= w && y + 1 >= h);
      r.fmax = frame_peak[21:0];
    end
    for (int k = 0; k < 3; k++) begin
      win[k] = win[3+k];
      win[3+k] = col[k];
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        frame_peak = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return due;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_grads.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    psel = 1; penable = 0; pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WIDTH:  cfg_width  = val & 32'h1FFF;
      REG_HEIGHT: cfg_height = val & 32'h1FFF;
      REG_AXIAL:  cfg_axial  = val & 32'h1;
      default: ;
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_pixel(pix_s p, bit typed, grad_s typed_res);
    int gap;
    grad_s r;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_chan_zero = p.ch[0];
    in_chan_one = p.ch[1];
    in_chan_two = p.ch[2];
    in_pixel_valid = p.valid;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (gradient_step(p, r))
      pending_grads.insert(pending_grads.size(), typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 0;
    while (pending_grads.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 600)) - 16'd300;
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 8000)) - 16'd4000;
    endcase
  endfunction

  task automatic run_frames(int unsigned wv, int unsigned hv, int unsigned ax,
                            int nframes, int mask_pct);
    pix_s p;
    int n;
    reg_write(REG_WIDTH, wv);
    reg_write(REG_HEIGHT, hv);
    reg_write(REG_AXIAL, ax);
    n = clamp_dim(wv) * clamp_dim(hv) * nframes;
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < 3; c++) p.ch[c] = rand_chan();
      p.valid = $urandom_range(0, 99) >= mask_pct;
      send_pixel(p, 0, '0);
    end
    frames_run += nframes;
    drain();
  endtask

  function automatic void add_frame(logic [15:0] lv, logic [15:0] mv, logic [15:0] rv,
                                    bit typed, grad_s res);
    stim_row_s row;
    for (int i = 0; i < 9; i++) begin
      row.pix.valid = 1;
      row.pix.ch = {3{(i % 3 == 0) ? lv : (i % 3 == 1) ? mv : rv}};
      row.typed = typed && (i == 8);
      row.res = res;
      directed_rows.insert(directed_rows.size(), row);
    end
  endfunction

  // Receiver: random stalls, one long hold-off to back the block up
  initial begin
    int gap;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = (results_seen == 40) ? 600 :
            ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
      if (gap > 0) begin
        out_stall = 1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result mag=%0d", out_magnitude);
      end else begin
        grad_s e;
        e = pending_grads.pop_front();
        if (e.mag !== out_magnitude || e.dir !== out_direction ||
            e.last !== out_frame_last || e.fmax !== out_frame_max) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: exp mag=%0d dir=%0d last=%0d max=%0d, got %0d %0d %0d %0d",
                     results_seen, e.mag, $signed(e.dir), e.last, e.fmax,
                     out_magnitude, $signed(out_direction), out_frame_last,
                     out_frame_max);
        end
      end
    end
  end

  initial begin
    grad_s zero_last;
    rst_n = 0;
    in_valid = 0; in_chan_zero = 0; in_chan_one = 0; in_chan_two = 0;
    in_pixel_valid = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cfg_width = WIDTH_RST; cfg_height = HEIGHT_RST; cfg_axial = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_pos = 0; row_pos = 0; frame_peak = 0;
    mismatches = 0; results_seen = 0; items_sent = 0; frames_run = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Flat frame gives a zero vector; left-high frame points at pi;
    // then the full-scale rising edge.
    zero_last = '{mag: 0, dir: 0, last: 1, fmax: 0};
    add_frame(16'd100, 16'd100, 16'd100, 1, zero_last);
    add_frame(16'h7FFF, 16'h0000, 16'h8000, 0, '0);
    add_frame(16'h8000, 16'h0000, 16'h7FFF, 0, '0);
    reg_write(REG_WIDTH, 3);
    reg_write(REG_HEIGHT, 3);
    reg_write(REG_AXIAL, 0);
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].res);
    frames_run += 3;
    drain();

    // Clamped small sizes, mostly unmasked, then heavily masked
    run_frames(1, 3, 1, 2, 5);
    run_frames(2, 0, 0, 1, 85);

    while (items_sent < RANDOM_ITEMS) begin
      run_frames($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12),
                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6),
                 $urandom_range(0, 1), $urandom_range(1, 3),
                 $urandom_range(0, 1) ? 0 : 4);
    end

    $display("covered %0d pixel items over %0d frames, %0d results checked",
             items_sent, frames_run, results_seen);
    $display("sizes from clamped 3x3 up to 12x6, both axial settings, masked windows");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
